@@ design/ptcp_pkg.sv @@
// Shared types, constants and arithmetic step functions for plane_to_camera_pose.
// Used by the top level and the testbench; depends on nothing.
package ptcp_pkg;

	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;
	localparam int NLANE      = 7;
	// s1..s3, divider load, divider steps, root load, root steps, product, row build
	localparam int NSTG       = 3 + 1 + DIV_STEPS + 1 + SQRT_STEPS + 2;

	// Ratio lanes: each computes a magnitude sqrt(num/den).
	localparam int LN_XA = 0;
	localparam int LN_XB = 1;
	localparam int LN_ZA = 2;
	localparam int LN_ZB = 3;
	localparam int LN_ZC = 4;
	localparam int LN_YP = 5;
	localparam int LN_TT = 6;

	localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
	localparam logic [63:0] ONE_Q62  = 64'h4000_0000_0000_0000;
	localparam logic [31:0] T_SAT    = 32'h8000_0000;
	localparam logic [1:0]  ROW_LAST = 2'd2;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ALONG_Z = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		logic    na;
		logic    nb;
		logic    nc;
		logic    sneg;
		logic    sat;
		status_t status;
	} side_t;

	typedef struct packed {
		logic [63:0] r;
		logic [63:0] y;
		logic [63:0] q;
		logic [63:0] sh;
		logic        eq;
	} div_t;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
		logic [63:0] v;
	} sq_t;

	typedef struct packed {
		logic [31:0] c0;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] t;
	} row_t;

	// One restoring division step: one quotient bit.
	function automatic div_t div_step(input div_t d);
		logic [64:0] rr;
		div_t        n;
		rr = {d.r, d.sh[63]};
		n  = d;
		if (rr >= {1'b0, d.y}) begin
			n.r = 64'(rr - {1'b0, d.y});
			n.q = {d.q[62:0], 1'b1};
		end else begin
			n.r = rr[63:0];
			n.q = {d.q[62:0], 1'b0};
		end
		n.sh = {d.sh[62:0], 1'b0};
		return n;
	endfunction

	// One digit-by-digit square root step: one root bit.
	function automatic sq_t sq_step(input sq_t s);
		logic [34:0] rem2;
		logic [34:0] trial;
		sq_t         n;
		rem2  = {s.rem[32:0], s.v[63:62]};
		trial = {1'b0, s.root, 2'b01};
		n     = s;
		if (rem2 >= trial) begin
			n.rem  = rem2 - trial;
			n.root = {s.root[30:0], 1'b1};
		end else begin
			n.rem  = rem2;
			n.root = {s.root[30:0], 1'b0};
		end
		n.v = {s.v[61:0], 2'b00};
		return n;
	endfunction

	function automatic logic [31:0] enc(input logic [31:0] mag, input logic neg);
		return neg ? 32'(32'd0 - mag) : mag;
	endfunction

endpackage

@@ design/ptcp_plane_if.sv @@
// Input channel of plane_to_camera_pose: one plane a,b,c,d in signed Q8.24.
// Depends on nothing.
interface ptcp_plane_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] plane_a;
	logic signed [31:0] plane_b;
	logic signed [31:0] plane_c;
	logic signed [31:0] plane_d;

	modport source (output valid, plane_a, plane_b, plane_c, plane_d, input ready);
	modport sink   (input valid, plane_a, plane_b, plane_c, plane_d, output ready);
endinterface

@@ design/ptcp_pose_if.sv @@
// Output channel of plane_to_camera_pose: one row of R with its translation entry.
// Depends on nothing.
interface ptcp_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] rot_col0;
	logic signed [31:0] rot_col1;
	logic signed [31:0] rot_col2;
	logic signed [31:0] trans_entry;
	logic        [1:0]  row_index;
	logic        [1:0]  status;
	logic               last_row;

	modport source (output valid, rot_col0, rot_col1, rot_col2, trans_entry, row_index,
		status, last_row, input ready);
	modport sink   (input valid, rot_col0, rot_col1, rot_col2, trans_entry, row_index,
		status, last_row, output ready);
endinterface

@@ design/plane_to_camera_pose.sv @@
// Camera pose from a plane: fully pipelined ratio, root and product datapath.
// Depends on ptcp_pkg, ptcp_plane_if and ptcp_pose_if.
//
// Each plane transfer yields three row transfers (rows 0, 1, 2, last_row on row 2).
// The pipeline is 103 register stages deep: magnitudes, squares, sums, a 64-step
// restoring divider and a 32-step square root for seven ratios in parallel, a
// product stage and a row build stage. A plane can enter in every cycle in which the
// pipeline advances. The output register shows one row per cycle while pose.ready
// is high, so the sustained rate is one plane per three rows, set by the row output.
// The pipeline advances as a whole whenever its last stage is empty or hands its
// item to the output register.
module plane_to_camera_pose
	import ptcp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	ptcp_plane_if.sink  plane,
	ptcp_pose_if.source pose
);

	logic [NSTG-1:0] vld_s;
	logic            adv;
	logic            load;
	logic            busy_q;
	logic [1:0]      row_q;
	row_t            rows_q [3];
	status_t         status_q;

	// Stage 1: magnitudes, signs, status.
	logic [31:0] ma_s1, mb_s1, mc_s1, md_s1;
	side_t       side_s1;
	// Stage 2: squares.
	logic [63:0] a2_s2, b2_s2, c2_s2, d2_s2;
	side_t       side_s2;
	// Stage 3: sums.
	logic [63:0] a2_s3, b2_s3, c2_s3, d2_s3, p_s3, n2_s3;
	side_t       side_s3;

	div_t  div_s  [DIV_STEPS+1][NLANE];
	side_t dside_s[DIV_STEPS+1];
	sq_t   sq_s   [SQRT_STEPS+1][NLANE];
	side_t qside_s[SQRT_STEPS+1];

	logic [31:0] mag_s5 [NLANE];
	logic [30:0] y0_s5, y1_s5;
	side_t       side_s5;
	row_t        rows_s6 [3];
	status_t     status_s6;

	assign load        = vld_s[NSTG-1] && (!busy_q || (pose.ready && row_q == ROW_LAST));
	assign adv         = !vld_s[NSTG-1] || load;
	assign plane.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-2:0], plane.valid};
		end
	end

	function automatic logic [31:0] mag_of(input logic [31:0] raw);
		return raw[31] ? 32'(32'd0 - raw) : raw;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			ma_s1 <= mag_of(plane.plane_a);
			mb_s1 <= mag_of(plane.plane_b);
			mc_s1 <= mag_of(plane.plane_c);
			md_s1 <= mag_of(plane.plane_d);
			side_s1.na   <= plane.plane_a[31];
			side_s1.nb   <= plane.plane_b[31];
			side_s1.nc   <= plane.plane_c[31];
			side_s1.sneg <= !plane.plane_d[31];
			side_s1.sat  <= 1'b0;
			if (plane.plane_a == 32'd0 && plane.plane_b == 32'd0 && plane.plane_c == 32'd0)
				side_s1.status <= ST_INVALID;
			else if (plane.plane_a == 32'd0 && plane.plane_b == 32'd0)
				side_s1.status <= ST_ALONG_Z;
			else if (plane.plane_d == 32'd0)
				side_s1.status <= ST_INVALID;
			else
				side_s1.status <= ST_OK;

			a2_s2   <= ma_s1 * ma_s1;
			b2_s2   <= mb_s1 * mb_s1;
			c2_s2   <= mc_s1 * mc_s1;
			d2_s2   <= md_s1 * md_s1;
			side_s2 <= side_s1;

			a2_s3   <= a2_s2;
			b2_s3   <= b2_s2;
			c2_s3   <= c2_s2;
			d2_s3   <= d2_s2;
			p_s3    <= a2_s2 + b2_s2;
			n2_s3   <= a2_s2 + b2_s2 + c2_s2;
			side_s3 <= side_s2;
		end
	end

	// Divider load: numerator, denominator per lane; t lane divides d^2*2^34 by N2.
	function automatic div_t div_load(input logic [63:0] x, input logic [63:0] y);
		div_t d;
		d.r  = x;
		d.y  = y;
		d.q  = '0;
		d.sh = '0;
		d.eq = (x == y);
		return d;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0][LN_XA] <= div_load(a2_s3, p_s3);
			div_s[0][LN_XB] <= div_load(b2_s3, p_s3);
			div_s[0][LN_ZA] <= div_load(a2_s3, n2_s3);
			div_s[0][LN_ZB] <= div_load(b2_s3, n2_s3);
			div_s[0][LN_ZC] <= div_load(c2_s3, n2_s3);
			div_s[0][LN_YP] <= div_load(p_s3, n2_s3);
			div_s[0][LN_TT] <= '{r: {30'd0, d2_s3[63:30]}, y: n2_s3, q: 64'd0,
				sh: {d2_s3[29:0], 34'd0}, eq: 1'b0};
			// The offset saturates when d^2/N2 reaches 2^30.
			dside_s[0]      <= '{na: side_s3.na, nb: side_s3.nb, nc: side_s3.nc,
				sneg: side_s3.sneg, sat: ({30'd0, d2_s3} >= {n2_s3, 30'd0}),
				status: side_s3.status};
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (adv) div_s[k][l] <= div_step(div_s[k-1][l]);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) dside_s[k] <= dside_s[k-1];
		end
	end

	// Ratio lanes carry x*2^64/y; two bits are dropped to get x*2^62/y.
	for (genvar l = 0; l < NLANE; l++) begin : g_sqload
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[0][l].rem  <= '0;
				sq_s[0][l].root <= '0;
				if (l == LN_TT)
					sq_s[0][l].v <= div_s[DIV_STEPS][l].q;
				else if (div_s[DIV_STEPS][l].eq)
					sq_s[0][l].v <= ONE_Q62;
				else
					sq_s[0][l].v <= {2'b00, div_s[DIV_STEPS][l].q[63:2]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) qside_s[0] <= dside_s[DIV_STEPS];
	end

	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sq
		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (adv) sq_s[k][l] <= sq_step(sq_s[k-1][l]);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) qside_s[k] <= qside_s[k-1];
		end
	end

	// Rounded magnitudes and the two products of the middle column.
	logic [31:0] mag_c [NLANE];
	logic [61:0] prod0, prod1;

	for (genvar l = 0; l < NLANE; l++) begin : g_mag
		logic [32:0] inc;
		assign inc      = {1'b0, sq_s[SQRT_STEPS][l].root} + 33'd1;
		assign mag_c[l] = inc[32:1];
	end

	assign prod0 = 62'(mag_c[LN_ZC][30:0] * mag_c[LN_XA][30:0]) + 62'(ONE_Q30 >> 1);
	assign prod1 = 62'(mag_c[LN_ZC][30:0] * mag_c[LN_XB][30:0]) + 62'(ONE_Q30 >> 1);

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s5  <= mag_c;
			y0_s5   <= prod0[60:30];
			y1_s5   <= prod1[60:30];
			side_s5 <= qside_s[SQRT_STEPS];
		end
	end

	logic [31:0] tm;
	assign tm = side_s5.sat ? T_SAT : mag_s5[LN_TT];

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s6 <= side_s5.status;
			if (side_s5.status == ST_OK) begin
				rows_s6[0] <= '{c0: enc(mag_s5[LN_XB], side_s5.sneg == side_s5.nb),
					c1: enc({1'b0, y0_s5}, side_s5.na == side_s5.nc),
					c2: enc(mag_s5[LN_ZA], side_s5.sneg ^ side_s5.na), t: 32'd0};
				rows_s6[1] <= '{c0: enc(mag_s5[LN_XA], side_s5.sneg ^ side_s5.na),
					c1: enc({1'b0, y1_s5}, side_s5.nb == side_s5.nc),
					c2: enc(mag_s5[LN_ZB], side_s5.sneg ^ side_s5.nb), t: 32'd0};
				rows_s6[2] <= '{c0: 32'd0, c1: mag_s5[LN_YP],
					c2: enc(mag_s5[LN_ZC], side_s5.sneg ^ side_s5.nc), t: enc(tm, 1'b1)};
			end else begin
				rows_s6[0] <= '{c0: ONE_Q30, c1: 32'd0, c2: 32'd0, t: 32'd0};
				rows_s6[1] <= '{c0: 32'd0, c1: ONE_Q30, c2: 32'd0, t: 32'd0};
				rows_s6[2] <= '{c0: 32'd0, c1: 32'd0, c2: ONE_Q30, t: 32'd0};
			end
		end
	end

	// Output register: holds one finished item and shows its rows in turn.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= 2'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q  <= 2'd0;
		end else if (busy_q && pose.ready) begin
			if (row_q == ROW_LAST) busy_q <= 1'b0;
			else row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rows_q   <= rows_s6;
			status_q <= status_s6;
		end
	end

	assign pose.valid       = busy_q;
	assign pose.rot_col0    = rows_q[row_q].c0;
	assign pose.rot_col1    = rows_q[row_q].c1;
	assign pose.rot_col2    = rows_q[row_q].c2;
	assign pose.trans_entry = rows_q[row_q].t;
	assign pose.row_index   = row_q;
	assign pose.status      = status_q;
	assign pose.last_row    = (row_q == ROW_LAST);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!plane.ready |-> (vld_s[NSTG-1] && busy_q))
		else $error("input stalled without a waiting item");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid |-> (pose.row_index == 2'd0 || pose.row_index == 2'd1
			|| pose.row_index == ROW_LAST))
		else $error("row index out of range");

	a_t_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pose.valid && pose.row_index != ROW_LAST) |-> pose.trans_entry == 32'd0)
		else $error("nonzero translation on rows 0 or 1");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(pose.valid && pose.status != ST_OK && pose.row_index == 2'd0)
		|-> (pose.rot_col0 == ONE_Q30 && pose.rot_col1 == 32'd0))
		else $error("special case without identity");

endmodule

@@ tb/tb_plane_to_camera_pose.sv @@
// Self-checking testbench for plane_to_camera_pose: drives planes, predicts the three pose rows.
// Depends on ptcp_pkg, ptcp_plane_if and ptcp_pose_if from the design folder.
module tb_plane_to_camera_pose
	import ptcp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] col0;
		logic [31:0] col1;
		logic [31:0] col2;
		logic [31:0] trans;
		logic [1:0]  row;
		status_t     status;
		logic        last;
	} pose_row_t;

	logic clk;
	logic arst_n;
	ptcp_plane_if plane ();
	ptcp_pose_if  pose ();

	plane_to_camera_pose dut (.clk(clk), .arst_n(arst_n), .plane(plane), .pose(pose));

	pose_row_t expected_rows[$];
	int        send_idle_pct;
	int        recv_stall_pct;
	int        mismatches;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// floor(x * 2^k / y) by shifting the remainder one bit at a time
	function automatic logic [63:0] scaled_quotient(logic [63:0] x, logic [63:0] y, int k);
		logic [63:0] q;
		logic [63:0] r;
		logic        carry;
		q = x / y;
		r = x % y;
		for (int i = 0; i < k; i++) begin
			carry = r[63];
			r = r << 1;
			q = q << 1;
			if (carry || r >= y) begin
				r = r - y;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] ratio_mag(logic [63:0] x, logic [63:0] y);
		return (floor_root(scaled_quotient(x, y, 62)) + 1) >> 1;
	endfunction

	function automatic logic [31:0] signed_q(logic [63:0] mag, logic neg);
		logic [63:0] v;
		v = neg ? (64'd0 - mag) : mag;
		return v[31:0];
	endfunction

	function automatic logic [63:0] magnitude(logic [31:0] raw);
		return raw[31] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
	endfunction

	// Queues the three rows of the pose that one plane should produce.
	task automatic predict_pose(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
		logic [63:0] ma, mb, mc, md, a2, b2, c2, d2, p, n2;
		logic [63:0] xa, xb, za, zb, zc, yp, y0, y1, tm;
		logic        sneg;
		logic [31:0] rot[3][3];
		logic [31:0] trans[3];
		status_t     st;
		pose_row_t   row;
		ma = magnitude(a);
		mb = magnitude(b);
		mc = magnitude(c);
		md = magnitude(d);
		for (int r = 0; r < 3; r++) begin
			trans[r] = 0;
			for (int j = 0; j < 3; j++) rot[r][j] = (r == j) ? ONE_Q30 : 32'd0;
		end
		if (ma == 0 && mb == 0 && mc == 0) st = ST_INVALID;
		else if (ma == 0 && mb == 0) st = ST_ALONG_Z;
		else if (md == 0) st = ST_INVALID;
		else st = ST_OK;
		if (st == ST_OK) begin
			a2 = ma * ma;
			b2 = mb * mb;
			c2 = mc * mc;
			d2 = md * md;
			p = a2 + b2;
			n2 = p + c2;
			// The sign of the zw axis is opposite to the sign of d.
			sneg = !d[31];
			xa = ratio_mag(a2, p);
			xb = ratio_mag(b2, p);
			za = ratio_mag(a2, n2);
			zb = ratio_mag(b2, n2);
			zc = ratio_mag(c2, n2);
			yp = ratio_mag(p, n2);
			y0 = (zc * xa + 64'(ONE_Q30 >> 1)) >> 30;
			y1 = (zc * xb + 64'(ONE_Q30 >> 1)) >> 30;
			rot[0][0] = signed_q(xb, !(sneg ^ b[31]));
			rot[0][1] = signed_q(y0, !(a[31] ^ c[31]));
			rot[0][2] = signed_q(za, sneg ^ a[31]);
			rot[1][0] = signed_q(xa, sneg ^ a[31]);
			rot[1][1] = signed_q(y1, !(b[31] ^ c[31]));
			rot[1][2] = signed_q(zb, sneg ^ b[31]);
			rot[2][0] = 0;
			rot[2][1] = signed_q(yp, 1'b0);
			rot[2][2] = signed_q(zc, sneg ^ c[31]);
			if (d2 / n2 >= 64'd1 << 30) begin
				tm = 64'd1 << 31;
			end else begin
				tm = (floor_root(scaled_quotient(d2, n2, 34)) + 1) >> 1;
				if (tm > (64'd1 << 31)) tm = 64'd1 << 31;
			end
			trans[2] = signed_q(tm, 1'b1);
		end
		for (int r = 0; r < 3; r++) begin
			row.col0 = rot[r][0];
			row.col1 = rot[r][1];
			row.col2 = rot[r][2];
			row.trans = trans[r];
			row.row = 2'(r);
			row.status = st;
			row.last = (r == 2);
			expected_rows.push_back(row);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose.ready <= 1'b0;
		end else begin
			pose.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pose_row_t want;
		if (arst_n && pose.valid && pose.ready) begin
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected row transfer, row %0d", pose.row_index);
			end else begin
				want = expected_rows.pop_front();
				if (pose.rot_col0 !== want.col0 || pose.rot_col1 !== want.col1 ||
						pose.rot_col2 !== want.col2 || pose.trans_entry !== want.trans ||
						pose.row_index !== want.row || pose.status !== want.status ||
						pose.last_row !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"row mismatch: exp %h %h %h %h r%0d s%0d l%0d, ",
							"got %h %h %h %h r%0d s%0d l%0d"},
							want.col0, want.col1, want.col2, want.trans, want.row, want.status,
							want.last, pose.rot_col0, pose.rot_col1, pose.rot_col2,
							pose.trans_entry, pose.row_index, pose.status, pose.last_row);
				end
			end
		end
	end

	// Valid stays high between back-to-back transfers; it only drops for a gap.
	task automatic send_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			plane.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		plane.valid <= 1'b1;
		plane.plane_a <= a;
		plane.plane_b <= b;
		plane.plane_c <= c;
		plane.plane_d <= d;
		do @(posedge clk); while (!plane.ready);
		predict_pose(a, b, c, d);
	endtask

	task automatic drain_rows();
		plane.valid <= 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic test_special_cases();
		send_plane(0, 0, 0, 0);
		send_plane(0, 0, 0, 32'h0100_0000);
		send_plane(0, 0, 32'h0100_0000, 32'h8000_0000);
		send_plane(0, 0, 32'h8000_0000, 0);
		send_plane(32'h0100_0000, 0, 0, 0);
		send_plane(0, 32'hFF00_0000, 32'h0100_0000, 0);
	endtask

	task automatic test_extremes();
		send_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_plane(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		send_plane(32'h0000_0001, 0, 0, 32'h7FFF_FFFF);
		send_plane(0, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001);
		send_plane(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h8000_0000);
		send_plane(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'hFF00_0000);
		send_plane(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h7F00_0000);
		send_plane(32'hF000_0000, 32'h0800_0000, 32'hFC00_0000, 32'h0200_0000);
	endtask

	function automatic logic [31:0] random_coef();
		logic [31:0] v;
		v = $urandom;
		// Spread magnitudes so both tiny and huge ratios occur.
		return $signed(v) >>> $urandom_range(31);
	endfunction

	task automatic test_random_planes(int count);
		logic [31:0] a, b, c, d;
		for (int i = 0; i < count; i++) begin
			a = random_coef();
			b = random_coef();
			c = random_coef();
			d = random_coef();
			case ($urandom_range(19))
				0: begin a = 0; b = 0; end
				1: d = 0;
				2: begin a = 0; b = 0; c = 0; end
				3: a = 0;
				4: b = 0;
				default: ;
			endcase
			send_plane(a, b, c, d);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		plane.valid <= 1'b0;
		plane.plane_a <= 0;
		plane.plane_b <= 0;
		plane.plane_c <= 0;
		plane.plane_d <= 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_extremes();
		drain_rows();
		test_random_planes(55);
		send_idle_pct = 46;
		test_random_planes(55);
		send_idle_pct = 0;
		recv_stall_pct = 46;
		test_random_planes(55);
		send_idle_pct = 6;
		recv_stall_pct = 6;
		test_random_planes(55);
		drain_rows();
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
